// ----- rtl/srsw_pkg.sv -----
// Shared types, constants and helpers of the selective-repeat send window.
package srsw_pkg;

  localparam int WINDOW      = 8;
  localparam int MAX_RESULTS = 8;
  localparam int Q_DEPTH     = 2;

  localparam int SEQ_W      = 32;
  localparam int AGE_W      = 16;
  localparam int OP_W       = 2;
  localparam int KIND_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SPAN_W     = $clog2(WINDOW + 1);
  localparam int CNT_W      = $clog2(MAX_RESULTS + 1);
  localparam int Q_PTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_SEND = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK  = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK = 2'd2;

  localparam logic [KIND_W-1:0] KIND_GRANT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REFUSE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TAKEN   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_IGNORED = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RETX    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_IDLE    = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END     = 2'd2;

  localparam logic [AGE_W-1:0] TIMEOUT_RST = 16'd100;
  localparam logic [SEQ_W-1:0] FIRST_RST   = 32'd2;
  localparam logic [SEQ_W-1:0] END_RST     = 32'd2;

  typedef enum logic [2:0] {
    CMD_SEND    = 3'd0,
    CMD_ACK     = 3'd1,
    CMD_ACK_BAD = 3'd2,
    CMD_TICK    = 3'd3,
    CMD_NOP     = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [SEQ_W-1:0] ack_num;
    logic             check_ok;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  seq_num;
    logic [SEQ_W-1:0]  window_base;
    logic [SEQ_W-1:0]  next_seq;
    logic              done_res;
    logic              last;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [SEQ_W-1:0] ack_num;
  } cmd_t;

  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                 input logic [SPAN_W-1:0] b);
    logic [SPAN_W:0] sum;
    sum = (SPAN_W+1)'(a) + (SPAN_W+1)'(b);
    if (sum >= (SPAN_W+1)'(WINDOW)) begin
      sum = sum - (SPAN_W+1)'(WINDOW);
    end
    return sum[SLOT_W-1:0];
  endfunction

endpackage

// ----- rtl/srsw_front.sv -----
// Front end: accepts input transactions and classifies them into commands.
module srsw_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  srsw_pkg::in_item_t in_data,
  output logic               push_valid,
  input  logic               push_ready,
  output srsw_pkg::cmd_t     push_cmd
);
  import srsw_pkg::*;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    push_cmd.ack_num = in_data.ack_num;
    case (in_data.op)
      OP_SEND: push_cmd.kind = CMD_SEND;
      OP_ACK:  push_cmd.kind = in_data.check_ok ? CMD_ACK : CMD_ACK_BAD;
      OP_TICK: push_cmd.kind = CMD_TICK;
      default: push_cmd.kind = CMD_NOP;
    endcase
  end

endmodule

// ----- rtl/srsw_cmdq.sv -----
// Short command queue between the front end and the window engine.
module srsw_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  srsw_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output srsw_pkg::cmd_t pop_cmd
);
  import srsw_pkg::*;

  cmd_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               push, pop;

  function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
    return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
  endfunction

  assign push_ready = (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- rtl/srsw_back.sv -----
// Window engine: grants, acknowledges, slides the base and scans for timeouts.
module srsw_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [srsw_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [srsw_pkg::SEQ_W-1:0]     cfg_data,
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  srsw_pkg::cmd_t                 cmd,
  output logic                           out_valid,
  input  logic                           out_ready,
  output srsw_pkg::out_item_t            out_data
);
  import srsw_pkg::*;

  typedef enum logic [2:0] {
    ST_FETCH = 3'b001,
    ST_SLIDE = 3'b010,
    ST_SCAN  = 3'b100
  } back_state_t;

  back_state_t       state_r, state_nxt;
  logic [SEQ_W-1:0]  base_r, base_nxt;
  logic [SEQ_W-1:0]  send_r, send_nxt;
  logic [SLOT_W-1:0] base_slot_r, base_slot_nxt;
  logic [SLOT_W-1:0] send_slot_r, send_slot_nxt;
  logic              acked_r [WINDOW];
  logic              acked_nxt [WINDOW];
  logic [AGE_W-1:0]  age_r [WINDOW];
  logic [AGE_W-1:0]  age_nxt [WINDOW];
  logic              fin_r, fin_nxt;
  logic [AGE_W-1:0]  timeout_r, timeout_nxt;
  logic [SEQ_W-1:0]  first_r, first_nxt;
  logic [SEQ_W-1:0]  end_r, end_nxt;
  logic [SPAN_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [SEQ_W-1:0]  pend_seq_r, pend_seq_nxt;
  logic              out_v_r, out_v_nxt;
  out_item_t         out_r, out_nxt;

  logic [SEQ_W-1:0]  span_full;
  logic [SPAN_W-1:0] span;
  logic              span_open;
  logic [SEQ_W:0]    ack_diff;
  logic              ack_in_win;
  logic [SLOT_W-1:0] ack_slot;
  logic [SLOT_W-1:0] rd_slot;
  logic [AGE_W-1:0]  age_rd, age_inc;
  logic              scan_due;
  logic              can_emit;
  logic              emit, emit_last, step_end, fin_step;
  logic [KIND_W-1:0] emit_kind;
  logic [SEQ_W-1:0]  emit_seq;

  assign out_valid = out_v_r;
  assign out_data  = out_r;
  assign can_emit  = !out_v_r || out_ready;

  assign span_full  = send_r - base_r;
  assign span       = span_full[SPAN_W-1:0];
  assign span_open  = (span < SPAN_W'(WINDOW));
  assign ack_diff   = {1'b0, cmd.ack_num} - {1'b0, base_r};
  assign ack_in_win = !ack_diff[SEQ_W] && (ack_diff[SEQ_W-1:0] < SEQ_W'(WINDOW));
  assign ack_slot   = slot_add(base_slot_r, ack_diff[SPAN_W-1:0]);
  assign rd_slot    = (state_r == ST_SCAN) ? slot_add(base_slot_r, idx_r) : base_slot_r;
  assign age_rd     = age_r[rd_slot];
  assign age_inc    = (age_rd == '1) ? age_rd : age_rd + AGE_W'(1);
  assign scan_due   = !acked_r[rd_slot] && (age_inc > timeout_r) &&
                      (cnt_r < CNT_W'(MAX_RESULTS));

  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    send_nxt      = send_r;
    base_slot_nxt = base_slot_r;
    send_slot_nxt = send_slot_r;
    acked_nxt     = acked_r;
    age_nxt       = age_r;
    fin_nxt       = fin_r;
    timeout_nxt   = timeout_r;
    first_nxt     = first_r;
    end_nxt       = end_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    pend_v_nxt    = pend_v_r;
    pend_seq_nxt  = pend_seq_r;
    out_v_nxt     = out_v_r;
    out_nxt       = out_r;
    emit          = 1'b0;
    emit_last     = 1'b1;
    emit_kind     = KIND_IDLE;
    emit_seq      = '0;
    step_end      = 1'b0;
    cmd_ready     = 1'b0;

    case (state_r)
      ST_FETCH: begin
        cmd_ready = can_emit;
        if (cmd_valid && can_emit) begin
          case (cmd.kind)
            CMD_SEND: begin
              emit     = 1'b1;
              step_end = 1'b1;
              if (span_open && (send_r < end_r)) begin
                acked_nxt[send_slot_r] = 1'b0;
                age_nxt[send_slot_r]   = '0;
                emit_kind              = KIND_GRANT;
                emit_seq               = send_r;
                send_nxt               = send_r + SEQ_W'(1);
                send_slot_nxt          = slot_add(send_slot_r, SPAN_W'(1));
              end else begin
                emit_kind = KIND_REFUSE;
              end
            end
            CMD_ACK: begin
              if (ack_in_win) begin
                acked_nxt[ack_slot] = 1'b1;
                state_nxt           = ST_SLIDE;
              end else begin
                emit      = 1'b1;
                step_end  = 1'b1;
                emit_kind = KIND_IGNORED;
              end
            end
            CMD_ACK_BAD: begin
              emit      = 1'b1;
              step_end  = 1'b1;
              emit_kind = KIND_IGNORED;
            end
            CMD_TICK: begin
              idx_nxt    = '0;
              cnt_nxt    = '0;
              pend_v_nxt = 1'b0;
              state_nxt  = ST_SCAN;
            end
            default: begin
              emit      = 1'b1;
              step_end  = 1'b1;
              emit_kind = KIND_IDLE;
            end
          endcase
        end
      end
      ST_SLIDE: begin
        if ((span != '0) && acked_r[rd_slot]) begin
          base_nxt      = base_r + SEQ_W'(1);
          base_slot_nxt = slot_add(base_slot_r, SPAN_W'(1));
        end else if (can_emit) begin
          emit      = 1'b1;
          step_end  = 1'b1;
          emit_kind = KIND_TAKEN;
          state_nxt = ST_FETCH;
        end
      end
      ST_SCAN: begin
        if (idx_r != span) begin
          // hold while a pending retransmit cannot leave
          if (!(scan_due && pend_v_r && !can_emit)) begin
            idx_nxt          = idx_r + SPAN_W'(1);
            age_nxt[rd_slot] = scan_due ? '0 : age_inc;
            if (scan_due) begin
              if (pend_v_r) begin
                emit      = 1'b1;
                emit_last = 1'b0;
                emit_kind = KIND_RETX;
                emit_seq  = pend_seq_r;
              end
              pend_v_nxt   = 1'b1;
              pend_seq_nxt = base_r + SEQ_W'(idx_r);
              cnt_nxt      = cnt_r + CNT_W'(1);
            end
          end
        end else if (can_emit) begin
          emit      = 1'b1;
          step_end  = 1'b1;
          emit_kind = pend_v_r ? KIND_RETX : KIND_IDLE;
          emit_seq  = pend_v_r ? pend_seq_r : '0;
          state_nxt = ST_FETCH;
        end
      end
      default: begin
        state_nxt = ST_FETCH;
      end
    endcase

    fin_step = fin_r || (base_nxt == end_r);
    if (step_end) begin
      fin_nxt = fin_step;
    end

    if (emit) begin
      out_v_nxt           = 1'b1;
      out_nxt.kind        = emit_kind;
      out_nxt.seq_num     = emit_seq;
      out_nxt.window_base = base_nxt;
      out_nxt.next_seq    = send_nxt;
      out_nxt.done_res    = fin_step;
      out_nxt.last        = emit_last;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end

    if (cfg_we) begin
      case (cfg_idx)
        CFG_TIMEOUT: timeout_nxt = cfg_data[AGE_W-1:0];
        CFG_FIRST: begin
          first_nxt     = cfg_data;
          base_nxt      = cfg_data;
          send_nxt      = cfg_data;
          base_slot_nxt = '0;
          send_slot_nxt = '0;
          fin_nxt       = 1'b0;
          for (int i = 0; i < WINDOW; i++) begin
            acked_nxt[i] = 1'b0;
            age_nxt[i]   = '0;
          end
        end
        CFG_END: end_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FETCH;
      base_r      <= FIRST_RST;
      send_r      <= FIRST_RST;
      base_slot_r <= '0;
      send_slot_r <= '0;
      fin_r       <= 1'b0;
      timeout_r   <= TIMEOUT_RST;
      first_r     <= FIRST_RST;
      end_r       <= END_RST;
      idx_r       <= '0;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_v_r     <= 1'b0;
      for (int i = 0; i < WINDOW; i++) begin
        acked_r[i] <= 1'b0;
        age_r[i]   <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      send_r      <= send_nxt;
      base_slot_r <= base_slot_nxt;
      send_slot_r <= send_slot_nxt;
      fin_r       <= fin_nxt;
      timeout_r   <= timeout_nxt;
      first_r     <= first_nxt;
      end_r       <= end_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_v_r     <= out_v_nxt;
      acked_r     <= acked_nxt;
      age_r       <= age_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_seq_r <= pend_seq_nxt;
    out_r      <= out_nxt;
  end

endmodule

// ----- rtl/selective_repeat_send_window.sv -----
// Top level of the selective-repeat send window.
// Input channel in_valid/in_ready/in_data carries one request transaction:
// a send request, an arrived ack or a time tick. Result channel
// out_valid/out_ready/out_data returns one or more result transactions per
// request, the final one flagged by last. Configuration is a plain write
// port (cfg_we, cfg_idx, cfg_data): timeout, first sequence, end sequence;
// writing the first sequence restarts the window.
// Requests pass a two-entry command queue, so the input takes new
// transactions while the engine works or the output is stalled, until the
// queue is full; the engine pops each request from the queue head.
// Engine steps per request, the last of which loads the output register:
// send, ignored ack or unknown op: fetch; taken ack: fetch, one slide step
// per slot the base slides (up to the window size), result; tick: fetch,
// one scan step per outstanding slot (up to the window size), result.
// A stalled receiver holds the engine at fetch, and before each result it must
// load, while the output register still holds an untaken result.
// Reset (synchronous, active low) loads timeout 100, first and end
// sequence 2, and clears all slots; no memory clearing pass is needed.
module selective_repeat_send_window (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [srsw_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [srsw_pkg::SEQ_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  srsw_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output srsw_pkg::out_item_t            out_data
);
  import srsw_pkg::*;

  logic push_valid, push_ready;
  logic pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  srsw_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  srsw_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  srsw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_nonlast_is_retx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.kind == KIND_RETX)
    else $error("non-final result is not a retransmit");

  a_seq_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != KIND_GRANT && out_data.kind != KIND_RETX
    |-> out_data.seq_num == '0)
    else $error("sequence number set on a result that carries none");

  a_window_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.next_seq >= out_data.window_base &&
                  (out_data.next_seq - out_data.window_base) <= SEQ_W'(WINDOW))
    else $error("outstanding span exceeds the window");

  a_grant_advances: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_GRANT
    |-> out_data.seq_num + SEQ_W'(1) == out_data.next_seq)
    else $error("granted number does not precede next sequence");

endmodule

// ----- sim/testbench.sv -----
// Testbench for the selective-repeat send window, checked against a window predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import srsw_pkg::*;

  localparam logic [OP_W-1:0]      OP_UNDEF  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 31;

  typedef struct packed {
    in_item_t item;
    logic     rel;
  } req_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [SEQ_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  req_t pending_reqs[$];
  out_item_t expected_results[$];
  req_t nxt;
  out_item_t want;
  out_item_t got;
  logic in_busy = 1'b0;
  logic calm = 1'b0;
  int in_gap = 0;
  int out_hold = 0;
  int errors = 0;
  int idle_cycles = 0;

  logic [AGE_W-1:0] r_timeout;
  logic [SEQ_W-1:0] r_first;
  logic [SEQ_W-1:0] r_end;
  logic [SEQ_W-1:0] w_base;
  logic [SEQ_W-1:0] w_next;
  logic w_acked [WINDOW];
  logic [AGE_W-1:0] w_age [WINDOW];
  logic w_done;

  selective_repeat_send_window dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int slot_of(input logic [SEQ_W-1:0] v);
    return int'(v % SEQ_W'(WINDOW));
  endfunction

  function automatic void restart_window();
    int i;
    w_base = r_first;
    w_next = r_first;
    for (i = 0; i < WINDOW; i++) begin
      w_acked[i] = 1'b0;
      w_age[i] = '0;
    end
    w_done = 1'b0;
  endfunction

  task automatic window_step(input in_item_t it);
    logic [SEQ_W:0] lim;
    logic [KIND_W-1:0] kinds [MAX_RESULTS];
    logic [SEQ_W-1:0] seqs [MAX_RESULTS];
    logic [SEQ_W-1:0] s;
    out_item_t r;
    int n;
    int p;
    int k;
    lim = {1'b0, w_base} + (SEQ_W+1)'(WINDOW);
    n = 0;
    case (it.op)
      OP_SEND: begin
        if ({1'b0, w_next} < lim && w_next < r_end) begin
          p = slot_of(w_next);
          w_acked[p] = 1'b0;
          w_age[p] = '0;
          kinds[0] = KIND_GRANT;
          seqs[0] = w_next;
          w_next++;
        end else begin
          kinds[0] = KIND_REFUSE;
          seqs[0] = '0;
        end
        n = 1;
      end
      OP_ACK: begin
        if (it.check_ok && it.ack_num >= w_base && {1'b0, it.ack_num} < lim) begin
          w_acked[slot_of(it.ack_num)] = 1'b1;
          while (w_base < w_next && w_acked[slot_of(w_base)]) w_base++;
          kinds[0] = KIND_TAKEN;
        end else begin
          kinds[0] = KIND_IGNORED;
        end
        seqs[0] = '0;
        n = 1;
      end
      OP_TICK: begin
        for (s = w_base; s < w_next; s++) begin
          p = slot_of(s);
          if (w_age[p] != '1) w_age[p]++;
          if (!w_acked[p] && w_age[p] > r_timeout && n < MAX_RESULTS) begin
            w_age[p] = '0;
            kinds[n] = KIND_RETX;
            seqs[n] = s;
            n++;
          end
        end
        if (n == 0) begin
          kinds[0] = KIND_IDLE;
          seqs[0] = '0;
          n = 1;
        end
      end
      default: begin
        kinds[0] = KIND_IDLE;
        seqs[0] = '0;
        n = 1;
      end
    endcase
    if (w_base == r_end) w_done = 1'b1;
    for (k = 0; k < n; k++) begin
      r.kind = kinds[k];
      r.seq_num = seqs[k];
      r.window_base = w_base;
      r.next_seq = w_next;
      r.done_res = w_done;
      r.last = (k == n - 1);
      expected_results.push_back(r);
    end
  endtask

  // rel: ack_num holds an offset from the window base at drive time
  function automatic void add_req(input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] ack,
                                  input logic ok, input logic rel);
    req_t q;
    q.item.op = op;
    q.item.ack_num = ack;
    q.item.check_ok = ok;
    q.rel = rel;
    pending_reqs.push_back(q);
  endfunction

  task automatic add_random(input int count);
    int i;
    int r;
    for (i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) add_req(OP_SEND, $urandom, 1'($urandom_range(0, 1)), 1'b0);
      else if (r < 63) add_req(OP_ACK, $urandom_range(0, 9), 1'b1, 1'b1);
      else if (r < 68) add_req(OP_ACK, $urandom_range(0, 9), 1'b0, 1'b1);
      else if (r < 73) add_req(OP_ACK, $urandom, 1'($urandom_range(0, 1)), 1'b0);
      else if (r < 94) add_req(OP_TICK, $urandom, 1'($urandom_range(0, 1)), 1'b0);
      else add_req(OP_UNDEF, $urandom, 1'($urandom_range(0, 1)), 1'b0);
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_busy || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // leaves cfg_we high; the caller lowers it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SEQ_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_TIMEOUT: r_timeout = val[AGE_W-1:0];
      CFG_FIRST: begin
        r_first = val;
        restart_window();
      end
      CFG_END: r_end = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [SEQ_W-1:0] t, input logic [SEQ_W-1:0] f,
                            input logic [SEQ_W-1:0] e);
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(CFG_TIMEOUT, t);
    write_reg(CFG_END, e);
    write_reg(CFG_FIRST, f);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(input string fname, input logic [SEQ_W-1:0] want_v,
                             input logic [SEQ_W-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, want_v, got_v);
      errors++;
    end
  endtask

  // driver: present the next request transaction
  always @(negedge clk) begin
    if (rst_n && !in_busy) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (pending_reqs.size() != 0) begin
        nxt = pending_reqs.pop_front();
        if (nxt.rel) nxt.item.ack_num = w_base + nxt.item.ack_num;
        in_data <= nxt.item;
        in_valid <= 1'b1;
        in_busy = 1'b1;
        in_gap = calm ? 0 : $urandom_range(0, 4);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      window_step(in_data);
      in_busy = 1'b0;
    end
  end

  // monitor: stall the result channel, then check each transaction
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got = out_data;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual kind %0d seq %0h",
                 $time, got.kind, got.seq_num);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("kind", SEQ_W'(want.kind), SEQ_W'(got.kind));
        check_field("seq_num", want.seq_num, got.seq_num);
        check_field("window_base", want.window_base, got.window_base);
        check_field("next_seq", want.next_seq, got.next_seq);
        check_field("done_res", SEQ_W'(want.done_res), SEQ_W'(got.done_res));
        check_field("last", SEQ_W'(want.last), SEQ_W'(got.last));
      end
      out_hold = calm ? 0 : $urandom_range(0, 4);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int ph;
    logic [SEQ_W-1:0] t;
    logic [SEQ_W-1:0] f;
    logic [SEQ_W-1:0] e;
    r_timeout = TIMEOUT_RST;
    r_first = FIRST_RST;
    r_end = END_RST;
    restart_window();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: window already done
    add_req(OP_SEND, '0, 1'b0, 1'b0);
    add_req(OP_ACK, '0, 1'b1, 1'b1);
    add_req(OP_TICK, '0, 1'b0, 1'b0);
    add_req(OP_UNDEF, '0, 1'b0, 1'b0);
    wait_drained();

    set_config(32'd1, 32'd0, 32'd20);
    repeat (9) add_req(OP_SEND, '0, 1'b0, 1'b0);
    add_req(OP_ACK, 32'd1, 1'b1, 1'b1);
    add_req(OP_ACK, 32'd0, 1'b1, 1'b1);
    add_req(OP_ACK, 32'd2, 1'b0, 1'b1);
    add_req(OP_ACK, SEQ_W'(WINDOW), 1'b1, 1'b1);
    add_req(OP_ACK, '1, 1'b1, 1'b0);
    add_req(OP_ACK, '0, 1'b1, 1'b0);
    add_req(OP_TICK, '0, 1'b0, 1'b0);
    add_req(OP_TICK, '1, 1'b1, 1'b0);
    add_req(OP_SEND, '1, 1'b1, 1'b0);
    add_req(OP_SEND, '0, 1'b0, 1'b0);
    add_req(OP_UNDEF, '1, 1'b1, 1'b0);
    wait_drained();

    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(CFG_SPARE, $urandom);
    @(negedge clk);
    cfg_we <= 1'b0;

    for (ph = 0; ph < PHASES; ph++) begin
      t = SEQ_W'($urandom_range(1, 6));
      f = $urandom;
      e = f + SEQ_W'($urandom_range(4, 24));
      case (ph)
        0: t = '0;
        1: t = 32'hA5A5_FFFF;
        2: begin
          f = '0;
          e = 32'd12;
        end
        3: begin
          f = 32'hFFFF_FFF0;
          e = '1;
        end
        4: begin
          f = '1;
          e = '1;
        end
        5: begin
          f = 32'd5;
          e = '0;
        end
        default: ;
      endcase
      set_config(t, f, e);
      calm = ($urandom_range(0, 3) == 0);
      add_random(PHASE_ITEMS);
      wait_drained();
    end

    repeat (30) @(negedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
